// ===== hdl/vstc_pkg.sv =====
`timescale 1ns / 1ps
package vstc_pkg;

	localparam int FRACTION_BITS = 16;

	localparam int ONE        = 1 << FRACTION_BITS;
	localparam int QUARTER    = ONE / 4;
	localparam int SPEED_LIM  = 4 * ONE;
	localparam int TOL_ZERO   = (ONE + 50) / 100;
	localparam int TOL_HOLD   = (ONE + 100) / 200;
	localparam int POWER_MIN  = (3 * ONE + 5) / 10;
	localparam int SLEW       = (ONE + 10) / 20;

	// reciprocal multipliers: floor(x / d) = (x * R) >> K over the value ranges used
	localparam int RCP10      = 3355444;   // K = 25, x < 2^21
	localparam int RCP10_SH   = 25;
	localparam int RCP100     = 2684355;   // K = 28, x < 2^21
	localparam int RCP100_SH  = 28;
	localparam int RCP7       = 149797;    // K = 20, x < 2^17
	localparam int RCP7_SH    = 20;
	localparam int DIV_BIAS   = 8192;      // keeps the /100 operand non-negative

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_ACCEL = 2'd1;
	localparam logic [1:0] OP_BRAKE = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef enum logic [3:0] {
		SP_NONE,
		SP_ACC,
		SP_BRK,
		SP_DV,
		SP_GOAL,
		SP_SMUL,
		SP_SDIV,
		SP_SPD,
		SP_TGT,
		SP_RMUL,
		SP_DPOW,
		SP_PWR,
		SP_OUT
	} dp_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_BRK,
		ST_DV,
		ST_GOAL,
		ST_SMUL,
		ST_SDIV,
		ST_SPD,
		ST_TGT,
		ST_RMUL,
		ST_DPOW,
		ST_PWR,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic     in_take;
		dp_step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic rev;
	} dp_status_t;

endpackage

// ===== hdl/vehicle_speed_throttle_controller_core.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | operation, request_on, time_step, fast_time
// out      | out_valid / out_stall| speed_now, speed_goal, power_level
// cfg      | cfg_valid / cfg_ready| max_speed
//
// A tick walks the one shared multiplier through each dependent product in
// order: DV, GOAL, SMUL, SDIV, SPD, TGT, an RMUL step for reverse thrust only,
// DPOW, PWR, then FIN. Command items run ACC or BRK, then FIN; unused-code items
// go straight to FIN. A new input is taken only once the controller is idle again.
// Reset clears speeds, power and request latches; max_speed resets to 58593.
// A result waits in the output register while the next item runs; only the
// final load step holds, while out_stall is high and the last result still waits.
module vehicle_speed_throttle_controller_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic               request_on,
	input  logic [19:0]        time_step,
	input  logic               fast_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [19:0] speed_now,
	output logic signed [19:0] speed_goal,
	output logic [16:0]        power_level,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [18:0]        max_speed
);

	vstc_pkg::dp_cmd_t    cmd;
	vstc_pkg::dp_status_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	vstc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vstc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_max_speed (max_speed),
		.request_on    (request_on),
		.time_step     (time_step),
		.fast_time     (fast_time),
		.speed_now     (speed_now),
		.speed_goal    (speed_goal),
		.power_level   (power_level)
	);

endmodule

// ===== hdl/vstc_ctrl.sv =====
`timescale 1ns / 1ps
module vstc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	output logic                out_valid,
	input  logic                out_stall,
	input  vstc_pkg::dp_status_t sts,
	output vstc_pkg::dp_cmd_t   cmd
);

	vstc_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vstc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q & out_stall;
		cmd.in_take = 1'b0;
		cmd.step    = vstc_pkg::SP_NONE;
		case (state_q)
			vstc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.in_take = 1'b1;
					case (operation)
						2'(vstc_pkg::OP_TICK):  state_d = vstc_pkg::ST_DV;
						2'(vstc_pkg::OP_ACCEL): state_d = vstc_pkg::ST_ACC;
						2'(vstc_pkg::OP_BRAKE): state_d = vstc_pkg::ST_BRK;
						default:                state_d = vstc_pkg::ST_FIN;
					endcase
				end
			end
			vstc_pkg::ST_ACC: begin
				cmd.step = vstc_pkg::SP_ACC;
				state_d  = vstc_pkg::ST_FIN;
			end
			vstc_pkg::ST_BRK: begin
				cmd.step = vstc_pkg::SP_BRK;
				state_d  = vstc_pkg::ST_FIN;
			end
			vstc_pkg::ST_DV: begin
				cmd.step = vstc_pkg::SP_DV;
				state_d  = vstc_pkg::ST_GOAL;
			end
			vstc_pkg::ST_GOAL: begin
				cmd.step = vstc_pkg::SP_GOAL;
				state_d  = vstc_pkg::ST_SMUL;
			end
			vstc_pkg::ST_SMUL: begin
				cmd.step = vstc_pkg::SP_SMUL;
				state_d  = vstc_pkg::ST_SDIV;
			end
			vstc_pkg::ST_SDIV: begin
				cmd.step = vstc_pkg::SP_SDIV;
				state_d  = vstc_pkg::ST_SPD;
			end
			vstc_pkg::ST_SPD: begin
				cmd.step = vstc_pkg::SP_SPD;
				state_d  = vstc_pkg::ST_TGT;
			end
			vstc_pkg::ST_TGT: begin
				cmd.step = vstc_pkg::SP_TGT;
				state_d  = sts.rev ? vstc_pkg::ST_RMUL : vstc_pkg::ST_DPOW;
			end
			vstc_pkg::ST_RMUL: begin
				cmd.step = vstc_pkg::SP_RMUL;
				state_d  = vstc_pkg::ST_DPOW;
			end
			vstc_pkg::ST_DPOW: begin
				cmd.step = vstc_pkg::SP_DPOW;
				state_d  = vstc_pkg::ST_PWR;
			end
			vstc_pkg::ST_PWR: begin
				cmd.step = vstc_pkg::SP_PWR;
				state_d  = vstc_pkg::ST_FIN;
			end
			vstc_pkg::ST_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.step    = vstc_pkg::SP_OUT;
					out_valid_d = 1'b1;
					state_d     = vstc_pkg::ST_IDLE;
				end
			end
			default: state_d = vstc_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != vstc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hdl/vstc_dp.sv =====
`timescale 1ns / 1ps
module vstc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vstc_pkg::dp_cmd_t    cmd,
	output vstc_pkg::dp_status_t sts,
	input  logic                 cfg_we,
	input  logic [18:0]          cfg_max_speed,
	input  logic                 request_on,
	input  logic [19:0]          time_step,
	input  logic                 fast_time,
	output logic signed [19:0]   speed_now,
	output logic signed [19:0]   speed_goal,
	output logic [16:0]          power_level
);

	logic [18:0]        max_speed_q;
	logic signed [19:0] goal_q, cur_q;
	logic [16:0]        power_q;
	logic               accel_q, brake_q;
	logic [19:0]        ts_q;
	logic               fast_q, req_q;
	logic signed [47:0] prod_q;
	logic [16:0]        tgt_q;
	logic               rev_q, hold_q, small_q, gnz_q;
	logic [16:0]        tgtf_q;

	logic signed [23:0] mul_a, mul_b;
	logic signed [47:0] prod;

	logic signed [21:0] g, cur, gs, gn, lim_s, dvs;
	logic [18:0]        lim;
	logic               clr;
	logic signed [21:0] step_v, cn, m_v;
	logic               stand, neg;
	logic signed [21:0] err, merr;
	logic [25:0]        m10;
	logic [16:0]        tgt0;
	logic               rev_c;
	logic [16:0]        tgtf;
	logic signed [17:0] diff, dpow, dmul, pdist, adist, ad, np;

	assign g   = 22'(goal_q);
	assign cur = 22'(cur_q);

	// shared multiplier, operands chosen by the step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		m_v   = 22'(prod_q[37:16] + 22'sd50);
		case (cmd.step)
			vstc_pkg::SP_DV: begin
				mul_a = 24'({1'b0, ts_q} + 21'd5);
				mul_b = 24'(vstc_pkg::RCP10);
			end
			vstc_pkg::SP_SMUL: begin
				mul_a = 24'($signed({1'b0, power_q}) - 18'sd16384);
				mul_b = 24'({1'b0, ts_q});
			end
			vstc_pkg::SP_SDIV: begin
				// round: floor((p + 50*ONE) / ONE) then bias for the /100
				m_v   = $signed(prod_q[37:16]) + 22'sd50;
				mul_a = 24'(m_v + 22'(vstc_pkg::DIV_BIAS * 100));
				mul_b = 24'(vstc_pkg::RCP100);
			end
			vstc_pkg::SP_RMUL: begin
				mul_a = 24'({(18'(vstc_pkg::ONE) - {1'b0, tgt_q}), 1'b0} + 19'd3);
				mul_b = 24'(vstc_pkg::RCP7);
			end
			vstc_pkg::SP_DPOW: begin
				mul_a = 24'(dpow);
				mul_b = 24'({1'b0, ts_q});
			end
			default: ;
		endcase
	end
	assign prod = 48'(mul_a) * 48'(mul_b);

	// target ramp
	always_comb begin
		lim   = (max_speed_q > 19'(vstc_pkg::SPEED_LIM)) ? 19'(vstc_pkg::SPEED_LIM)
			: max_speed_q;
		lim_s = $signed({3'b0, lim});
		dvs   = $signed({5'b0, prod_q[41:25]});
		clr   = 1'b0;
		gs    = g;
		gn    = g;
		if (accel_q) begin
			gs = g + dvs;
			if (g < 0 && gs >= 0) begin
				gn  = '0;
				clr = 1'b1;
			end else begin
				gn = gs;
			end
			if (gn > lim_s) gn = lim_s;
		end else if (brake_q) begin
			gs = g - dvs;
			if (g > 0 && gs <= 0) begin
				gn  = '0;
				clr = 1'b1;
			end else begin
				gn = gs;
			end
			if (gn < -lim_s) gn = -lim_s;
		end
		if (gn > 22'sd262144) gn = 22'sd262144;
		if (gn < -22'sd262144) gn = -22'sd262144;
	end

	// speed integration
	always_comb begin
		step_v = $signed({7'b0, prod_q[42:28]}) - 22'(vstc_pkg::DIV_BIAS);
		stand  = (cur > -22'(vstc_pkg::TOL_ZERO)) && (cur < 22'(vstc_pkg::TOL_ZERO));
		neg    = (stand && (g < 0)) || (cur < 0);
		if (!stand || (power_q > 17'(vstc_pkg::QUARTER))) begin
			cn = neg ? cur - step_v : cur + step_v;
			if (cn > 22'sd262144) cn = 22'sd262144;
			if (cn < -22'sd262144) cn = -22'sd262144;
		end else begin
			cn = '0;
		end
	end

	// power goal
	always_comb begin
		err   = g - cur;
		merr  = (err < 0) ? -err : err;
		m10   = 26'(merr) * 26'd10;
		if (m10 < 26'(vstc_pkg::POWER_MIN))   tgt0 = 17'(vstc_pkg::POWER_MIN);
		else if (m10 > 26'(vstc_pkg::ONE))    tgt0 = 17'(vstc_pkg::ONE);
		else                                  tgt0 = m10[16:0];
		rev_c = ((cur > 0) && (err < 0)) || ((cur < 0) && (err > 0));
	end
	assign sts.rev = rev_c;

	always_comb begin
		if (!gnz_q)                     tgtf = '0;
		else if (hold_q || small_q)     tgtf = 17'(vstc_pkg::QUARTER);
		else if (rev_q)                 tgtf = {3'b0, prod_q[33:20]};
		else                            tgtf = tgt_q;
		diff = $signed({1'b0, tgtf}) - $signed({1'b0, power_q});
		if (!gnz_q)                               dpow = -18'(vstc_pkg::SLEW);
		else if (diff > 18'(vstc_pkg::SLEW))      dpow = 18'(vstc_pkg::SLEW);
		else if (diff < -18'(vstc_pkg::SLEW))     dpow = -18'(vstc_pkg::SLEW);
		else                                      dpow = diff;
	end

	// power slew
	always_comb begin
		dmul  = $signed(prod_q[33:16]);
		pdist = $signed({1'b0, tgtf_q}) - $signed({1'b0, power_q});
		adist = (pdist < 0) ? -pdist : pdist;
		ad    = (dmul < 0) ? -dmul : dmul;
		np    = $signed({1'b0, power_q}) + dmul;
		if (np < 0) np = '0;
		if (np > 18'(vstc_pkg::ONE)) np = 18'(vstc_pkg::ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 19'd58593;
			goal_q      <= '0;
			cur_q       <= '0;
			power_q     <= '0;
			accel_q     <= 1'b0;
			brake_q     <= 1'b0;
		end else begin
			if (cfg_we) max_speed_q <= cfg_max_speed;
			case (cmd.step)
				vstc_pkg::SP_ACC: begin
					accel_q <= req_q;
					brake_q <= 1'b0;
				end
				vstc_pkg::SP_BRK: begin
					brake_q <= req_q;
					accel_q <= 1'b0;
				end
				vstc_pkg::SP_GOAL: begin
					goal_q <= gn[19:0];
					if (clr) begin
						accel_q <= 1'b0;
						brake_q <= 1'b0;
					end
				end
				vstc_pkg::SP_SPD: cur_q <= cn[19:0];
				vstc_pkg::SP_PWR: begin
					if (ad > adist) power_q <= tgtf_q;
					else            power_q <= np[16:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			ts_q   <= time_step;
			fast_q <= fast_time;
			req_q  <= request_on;
		end
		case (cmd.step)
			vstc_pkg::SP_DV, vstc_pkg::SP_SMUL, vstc_pkg::SP_SDIV,
			vstc_pkg::SP_RMUL:
				prod_q <= prod;
			vstc_pkg::SP_DPOW: begin
				prod_q <= prod + 48'sd32768;
				tgtf_q <= tgtf;
			end
			vstc_pkg::SP_TGT: begin
				tgt_q   <= tgt0;
				rev_q   <= rev_c;
				hold_q  <= merr <= 22'(vstc_pkg::TOL_HOLD);
				small_q <= (merr < 22'(vstc_pkg::TOL_ZERO)) && fast_q;
				gnz_q   <= (g >= 22'(vstc_pkg::TOL_ZERO)) || (g <= -22'(vstc_pkg::TOL_ZERO));
			end
			vstc_pkg::SP_OUT: begin
				speed_now   <= cur_q;
				speed_goal  <= goal_q;
				power_level <= power_q;
			end
			default: ;
		endcase
	end

endmodule
